### sv/rrt_pkg.sv
package rrt_pkg;

  localparam int TableSlots = 16;
  localparam int SlotW = 4;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_RECV = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [2:0] EV_ADDED = 3'd0;
  localparam logic [2:0] EV_REFUSED = 3'd1;
  localparam logic [2:0] EV_VERDICT = 3'd2;
  localparam logic [2:0] EV_RESEND = 3'd3;
  localparam logic [2:0] EV_GIVEUP = 3'd4;

  localparam logic [1:0] CFG_FIRST_WAIT = 2'd0;
  localparam logic [1:0] CFG_RETRY_WAIT = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] msg_type;
    logic [15:0] msg_id;
    logic [47:0] peer_mac;
    logic [15:0] reply_type;
    logic        expects_response;
    logic        is_response;
    logic        answer_is_ack;
    logic        unsolicited;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [3:0]  slot;
    logic [15:0] out_type;
    logic [15:0] out_id;
    logic [47:0] out_mac;
    logic        ack_needed;
    logic        matched;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] etype;
    logic [15:0] resp;
    logic [15:0] id;
    logic [47:0] mac;
    logic [2:0]  tries;
    logic [15:0] timer;
  } entry_t;

  // Operation applied by the head cell as the table rotates past it.
  typedef enum logic [3:0] {
    OP_IDLE = 4'b0001,
    OP_SEND = 4'b0010,
    OP_RECV = 4'b0100,
    OP_TICK = 4'b1000
  } op_t;

endpackage

### sv/rrt_cell.sv
module rrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  rrt_pkg::entry_t prev_in,
  output rrt_pkg::entry_t cur_out
);

  rrt_pkg::entry_t ent_r;
  rrt_pkg::entry_t ent_nxt;

  always_comb begin
    ent_nxt = shift ? prev_in : ent_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.etype <= ent_nxt.etype;
    ent_r.resp <= ent_nxt.resp;
    ent_r.id <= ent_nxt.id;
    ent_r.mac <= ent_nxt.mac;
    ent_r.tries <= ent_nxt.tries;
    ent_r.timer <= ent_nxt.timer;
  end

  assign cur_out = ent_r;

endmodule

### sv/request_retry_tracker.sv
// The table is a ring of 16 cells that rotates one slot per cycle past a head
// cell while an operation runs. A receive or a tick rotates the ring once; a
// send rotates it twice (search, then write), or once when it is refused. A send
// that expects no response, and an unknown kind, leave the ring still and give
// no result. busy stays high through the rotation and while a final result is
// pending, so the next item is accepted only once both are over. A send or
// receive gives its single result through the pend_r and res_r registers after
// the rotation ends. A tick gives one result per expiring slot in slot order,
// each issued when the next expiring slot is found, and the final one, with last
// set, after the rotation ends. Results cannot be held off by the receiver.
// Configuration is taken only while busy is low.
module request_retry_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rrt_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rrt_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int N = rrt_pkg::TableSlots;

  rrt_pkg::entry_t cell_q [N];
  rrt_pkg::entry_t cell_d [N];
  rrt_pkg::entry_t head_new;

  logic [15:0] first_wait_r, retry_wait_r;
  logic [2:0]  retry_limit_r;
  logic [15:0] id_cnt_r, id_cnt_nxt;
  rrt_pkg::op_t op_r, op_nxt;
  rrt_pkg::in_item_t it_r;
  logic [rrt_pkg::SlotW:0] pos_r, pos_nxt;
  logic [rrt_pkg::SlotW-1:0] pos_slot;
  logic shift;

  logic found_r, found_nxt;
  logic [rrt_pkg::SlotW-1:0] fslot_r, fslot_nxt;
  logic free_r, free_nxt;
  logic [rrt_pkg::SlotW-1:0] free_slot_r, free_slot_nxt;
  logic [15:0] ftype_r, ftype_nxt;
  rrt_pkg::out_item_t pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;
  rrt_pkg::out_item_t res_r, res_nxt;
  logic res_v_r, res_v_nxt;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      rrt_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (shift),
        .prev_in(cell_d[g]),
        .cur_out(cell_q[g])
      );
      if (g < N - 1) begin : g_link
        assign cell_d[g] = cell_q[g + 1];
      end else begin : g_head
        assign cell_d[g] = head_new;
      end
    end
  endgenerate

  assign busy = (op_r != rrt_pkg::OP_IDLE) || pend_v_r;
  assign shift = (op_r != rrt_pkg::OP_IDLE);
  assign pos_slot = pos_r[rrt_pkg::SlotW-1:0];
  assign cfg_ready = !busy;
  assign out_valid = res_v_r;
  assign out_item = res_r;

  always_comb begin
    rrt_pkg::entry_t e;
    logic rmatch, smatch;
    e = cell_q[0];
    head_new = e;
    op_nxt = op_r;
    pos_nxt = pos_r;
    id_cnt_nxt = id_cnt_r;
    found_nxt = found_r;
    fslot_nxt = fslot_r;
    free_nxt = free_r;
    free_slot_nxt = free_slot_r;
    ftype_nxt = ftype_r;
    pend_nxt = pend_r;
    pend_v_nxt = 1'b0;
    res_nxt = pend_r;
    res_v_nxt = pend_v_r;
    rmatch = e.valid && e.mac == it_r.peer_mac && e.id == it_r.msg_id
             && e.resp == it_r.msg_type;
    smatch = e.valid && e.etype == it_r.msg_type && e.mac == it_r.peer_mac;
    if (op_r == rrt_pkg::OP_IDLE) begin
      if (start && !busy) begin
        pos_nxt = '0;
        found_nxt = 1'b0;
        free_nxt = 1'b0;
        fslot_nxt = '0;
        free_slot_nxt = '0;
        ftype_nxt = in_item.msg_type;
        case (in_item.kind)
          rrt_pkg::KIND_SEND: op_nxt = in_item.expects_response ?
                                       rrt_pkg::OP_SEND : rrt_pkg::OP_IDLE;
          rrt_pkg::KIND_RECV: op_nxt = rrt_pkg::OP_RECV;
          rrt_pkg::KIND_TICK: op_nxt = rrt_pkg::OP_TICK;
          default: op_nxt = rrt_pkg::OP_IDLE;
        endcase
      end
    end else begin
      pos_nxt = pos_r + 1'b1;
      case (op_r)
        rrt_pkg::OP_SEND: begin
          if (pos_r[rrt_pkg::SlotW] == 1'b0) begin
            // First pass searches; second pass writes the chosen slot.
            if (smatch && !found_r) begin
              found_nxt = 1'b1;
              fslot_nxt = pos_slot;
            end
            if (!e.valid && !free_r) begin
              free_nxt = 1'b1;
              free_slot_nxt = pos_slot;
            end
            if (pos_slot == rrt_pkg::SlotW'(N - 1)) begin
              if (!found_nxt && !free_nxt) begin
                op_nxt = rrt_pkg::OP_IDLE;
                pend_nxt = '{rrt_pkg::EV_REFUSED, 4'd0, it_r.msg_type, 16'd0,
                             it_r.peer_mac, 1'b0, 1'b0, 1'b1};
                pend_v_nxt = 1'b1;
              end else if (!found_nxt) begin
                fslot_nxt = free_slot_nxt;
              end
            end
          end else begin
            if (pos_slot == fslot_r) begin
              head_new = '{1'b1, it_r.msg_type, it_r.reply_type, it_r.msg_id,
                           it_r.peer_mac, 3'd0, first_wait_r};
            end
            if (pos_slot == rrt_pkg::SlotW'(N - 1)) begin
              op_nxt = rrt_pkg::OP_IDLE;
              pend_nxt = '{rrt_pkg::EV_ADDED, fslot_r, it_r.msg_type, 16'd0,
                           it_r.peer_mac, 1'b0, 1'b0, 1'b1};
              pend_v_nxt = 1'b1;
            end
          end
        end
        rrt_pkg::OP_RECV: begin
          if (rmatch && !found_r) begin
            found_nxt = 1'b1;
            fslot_nxt = pos_slot;
            ftype_nxt = e.etype;
            if (it_r.is_response) begin
              head_new.valid = 1'b0;
            end
          end
          if (pos_slot == rrt_pkg::SlotW'(N - 1)) begin
            op_nxt = rrt_pkg::OP_IDLE;
            pend_nxt = '{rrt_pkg::EV_VERDICT, fslot_nxt, ftype_nxt, 16'd0,
                         it_r.peer_mac,
                         it_r.answer_is_ack && !(it_r.unsolicited && found_nxt),
                         it_r.is_response && found_nxt, 1'b1};
            pend_v_nxt = 1'b1;
          end
        end
        rrt_pkg::OP_TICK: begin
          res_v_nxt = 1'b0;
          pend_v_nxt = pend_v_r;
          if (e.valid && e.timer <= 16'd1 && pend_v_r) begin
            res_nxt = pend_r;
            res_nxt.last = 1'b0;
            res_v_nxt = 1'b1;
          end
          if (e.valid) begin
            if (e.timer > 16'd1) begin
              head_new.timer = e.timer - 16'd1;
            end else if ({1'b0, e.tries} + 4'd1 <= {1'b0, retry_limit_r}) begin
              head_new.tries = e.tries + 3'd1;
              head_new.id = id_cnt_r;
              head_new.timer = retry_wait_r;
              id_cnt_nxt = id_cnt_r + 16'd1;
              pend_nxt = '{rrt_pkg::EV_RESEND, pos_slot, e.etype, id_cnt_r,
                           e.mac, 1'b0, 1'b0, 1'b1};
              pend_v_nxt = 1'b1;
            end else begin
              head_new.valid = 1'b0;
              pend_nxt = '{rrt_pkg::EV_GIVEUP, pos_slot, e.etype, 16'd0,
                           e.mac, 1'b0, 1'b0, 1'b1};
              pend_v_nxt = 1'b1;
            end
          end
          if (pos_slot == rrt_pkg::SlotW'(N - 1)) begin
            op_nxt = rrt_pkg::OP_IDLE;
          end
        end
        default: op_nxt = rrt_pkg::OP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= rrt_pkg::OP_IDLE;
      pend_v_r <= 1'b0;
      res_v_r <= 1'b0;
      id_cnt_r <= '0;
      first_wait_r <= 16'd1000;
      retry_wait_r <= 16'd2000;
      retry_limit_r <= 3'd3;
    end else begin
      op_r <= op_nxt;
      pend_v_r <= pend_v_nxt;
      res_v_r <= res_v_nxt;
      id_cnt_r <= id_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rrt_pkg::CFG_FIRST_WAIT: first_wait_r <= cfg_data;
          rrt_pkg::CFG_RETRY_WAIT: retry_wait_r <= cfg_data;
          rrt_pkg::CFG_RETRY_LIMIT: retry_limit_r <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
    if (start && !busy) begin
      it_r <= in_item;
    end
    pos_r <= pos_nxt;
    found_r <= found_nxt;
    fslot_r <= fslot_nxt;
    free_r <= free_nxt;
    free_slot_r <= free_slot_nxt;
    ftype_r <= ftype_nxt;
    pend_r <= pend_nxt;
    res_r <= res_nxt;
  end

  a_last_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> !pend_v_r)
    else $error("last result issued while another is pending");
  a_tick_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (op_r == rrt_pkg::OP_TICK && pos_slot == rrt_pkg::SlotW'(N - 1))
    |=> op_r == rrt_pkg::OP_IDLE)
    else $error("tick did not end after one rotation");
  a_verdict_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.event_res != rrt_pkg::EV_VERDICT)
    |-> (!out_item.ack_needed && !out_item.matched))
    else $error("verdict flags set on a non-verdict result");

endmodule
